// ===== rtl/core/png_scanline_unfilter_macros.svh =====
// Assertion macros shared by the checker of png_scanline_unfilter.
// Needs no other file; included by bare name.
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define PSU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must also hold while and right after reset is applied.
`define PSU_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/psu_pkg.sv =====
// Package of png_scanline_unfilter: sizes, filter codes, register indexes,
// the stage record between control and datapath, and the Paeth predictor.
// Depends on nothing.
package psu_pkg;

   localparam int MAX_LINE_BYTES  = 32768;
   localparam int MAX_PIXEL_BYTES = 8;
   localparam int ROW_LIMIT       = 16384;

   localparam int LINE_AW = $clog2(MAX_LINE_BYTES);
   localparam int SLOT_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // Field and register widths
   localparam int BYTE_W = 8;
   localparam int BPP_W  = 4;
   localparam int LB_W   = 16;
   localparam int RT_W   = 15;
   localparam int COL_W  = 16;
   localparam int ROW_W  = 14;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYTES_PER_PIXEL = 2'd0,
      CSR_LINE_BYTES      = 2'd1,
      CSR_ROW_TOTAL       = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // One request on its way from control to the reconstruction stage
   typedef struct packed {
      logic                  compute;
      logic                  status;
      logic                  row_end;
      logic                  image_end;
      logic [BYTE_W-1:0]     data;
      filter_type            kind;
      logic [SLOT_W-1:0]     slot;
      logic                  has_left;
      logic                  has_up;
      logic [LINE_AW-1:0]    idx;
   } stage_type;

   // Paeth predictor: pick the neighbor closest to a + b - c
   function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] c);
      logic signed [BYTE_W+1:0] da;
      logic signed [BYTE_W+1:0] db;
      logic signed [BYTE_W+1:0] dc;
      logic        [BYTE_W+1:0] pa;
      logic        [BYTE_W+1:0] pb;
      logic        [BYTE_W+1:0] pc;
      logic        [BYTE_W-1:0] pick;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = da + db;
      pa = (da < 0) ? $unsigned(-da) : $unsigned(da);
      pb = (db < 0) ? $unsigned(-db) : $unsigned(db);
      pc = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

// ===== rtl/core/psu_channels.sv =====
// Request and response channel interfaces of png_scanline_unfilter.
// Depends on psu_pkg for the field widths.
interface psu_req_if;
   logic                          valid;
   logic                          ready;
   logic [psu_pkg::BYTE_W-1:0]    filtered_byte;

   modport source (output valid, output filtered_byte, input ready);
   modport sink   (input valid, input filtered_byte, output ready);
endinterface

interface psu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psu_pkg::BYTE_W-1:0]    pixel_byte;
   logic                          status;
   logic                          row_end;
   logic                          image_end;

   modport source (output valid, output pixel_byte, output status, output row_end,
                   output image_end, input ready);
   modport sink   (input valid, input pixel_byte, input status, input row_end,
                   input image_end, output ready);
endinterface

// ===== rtl/core/psu_line_ram.sv =====
// Simple dual-port RAM with registered read, used as the previous-row store.
// Depends on nothing.
module psu_line_ram #(
   parameter int DEPTH = 32768,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/psu_ctrl.sv =====
// Control of png_scanline_unfilter: configuration registers, row and column
// tracking, filter byte decode and the stage register. Depends on psu_pkg
// and psu_channels.
module psu_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   psu_req_if.sink                           req_if,
   input  logic                              csr_we,
   input  logic [psu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              stage_take,
   output logic                              stage_vld,
   output psu_pkg::stage_type                stage,
   output logic                              rd_en,
   output logic [psu_pkg::LINE_AW-1:0]       rd_addr
);

   logic [psu_pkg::BPP_W-1:0]  bpp_ff;
   logic [psu_pkg::LB_W-1:0]   line_ff;
   logic [psu_pkg::RT_W-1:0]   rows_ff;

   logic [psu_pkg::BPP_W-1:0]  bpp_eff;
   logic [psu_pkg::LB_W:0]     lb_eff;
   logic [psu_pkg::RT_W-1:0]   rt_eff;

   logic                       expect_ff, expect_in;
   logic                       failed_ff, failed_in;
   psu_pkg::filter_type        kind_ff, kind_in;
   logic [psu_pkg::COL_W-1:0]  col_ff, col_in;
   logic [psu_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [psu_pkg::SLOT_W-1:0] mod_ff [psu_pkg::MAX_PIXEL_BYTES];
   logic [psu_pkg::SLOT_W-1:0] mod_in [psu_pkg::MAX_PIXEL_BYTES];
   logic [psu_pkg::SLOT_W-1:0] mod_next [psu_pkg::MAX_PIXEL_BYTES];

   logic                       stage_vld_ff, stage_vld_in;
   psu_pkg::stage_type         stage_ff, stage_in;

   logic                       accept;
   logic                       row_end;
   logic                       last;
   logic                       bad_filter;
   logic [psu_pkg::LINE_AW-1:0] idx;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff  <= psu_pkg::BPP_W'(1);
         line_ff <= psu_pkg::LB_W'(1);
         rows_ff <= psu_pkg::RT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            psu_pkg::CSR_BYTES_PER_PIXEL: bpp_ff  <= csr_wdata[psu_pkg::BPP_W-1:0];
            psu_pkg::CSR_LINE_BYTES:      line_ff <= csr_wdata[psu_pkg::LB_W-1:0];
            psu_pkg::CSR_ROW_TOTAL:       rows_ff <= csr_wdata[psu_pkg::RT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers to their working range
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = psu_pkg::BPP_W'(1);
      end else if (bpp_ff > psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES)) begin
         bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES);
      end else begin
         bpp_eff = bpp_ff;
      end
      if (line_ff == '0) begin
         lb_eff = (psu_pkg::LB_W+1)'(1);
      end else if (32'(line_ff) > 32'(psu_pkg::MAX_LINE_BYTES)) begin
         lb_eff = (psu_pkg::LB_W+1)'(psu_pkg::MAX_LINE_BYTES);
      end else begin
         lb_eff = {1'b0, line_ff};
      end
      if (rows_ff == '0) begin
         rt_eff = psu_pkg::RT_W'(1);
      end else if (rows_ff > psu_pkg::RT_W'(psu_pkg::ROW_LIMIT)) begin
         rt_eff = psu_pkg::RT_W'(psu_pkg::ROW_LIMIT);
      end else begin
         rt_eff = rows_ff;
      end
   end

   // Row position of the current data byte
   assign accept     = req_if.valid && req_if.ready;
   assign row_end    = ((psu_pkg::LB_W+1)'(col_ff) + (psu_pkg::LB_W+1)'(1)) >= lb_eff;
   assign last       = row_end && ((psu_pkg::RT_W'(row_ff) + psu_pkg::RT_W'(1)) >= rt_eff);
   assign bad_filter = req_if.filtered_byte > {5'd0, psu_pkg::FILT_PAETH};

   always_comb begin
      if (32'(col_ff) >= 32'(psu_pkg::MAX_LINE_BYTES)) begin
         idx = psu_pkg::LINE_AW'(psu_pkg::MAX_LINE_BYTES - 1);
      end else begin
         idx = col_ff[psu_pkg::LINE_AW-1:0];
      end
   end

   // Column modulo every possible pixel size, kept incrementally
   always_comb begin
      for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
         if (32'(mod_ff[k]) + 1 == k + 1) begin
            mod_next[k] = '0;
         end else begin
            mod_next[k] = mod_ff[k] + psu_pkg::SLOT_W'(1);
         end
      end
   end

   // Next state and stage contents for an accepted request
   always_comb begin
      expect_in    = expect_ff;
      failed_in    = failed_ff;
      kind_in      = kind_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      mod_in       = mod_ff;
      stage_vld_in = stage_take ? 1'b0 : stage_vld_ff;
      stage_in     = stage_ff;
      if (accept) begin
         stage_in.data     = req_if.filtered_byte;
         stage_in.kind     = kind_ff;
         stage_in.slot     = mod_ff[psu_pkg::SLOT_W'(bpp_eff - psu_pkg::BPP_W'(1))];
         stage_in.has_left = psu_pkg::COL_W'(bpp_eff) <= col_ff;
         stage_in.has_up   = row_ff != '0;
         stage_in.idx      = idx;
         if (expect_ff) begin
            // Filter byte: decode, report only an invalid one
            expect_in = 1'b0;
            col_in    = '0;
            for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
               mod_in[k] = '0;
            end
            stage_in.compute   = 1'b0;
            stage_in.status    = 1'b1;
            stage_in.row_end   = 1'b0;
            stage_in.image_end = 1'b0;
            stage_vld_in       = 1'b0;
            if (!failed_ff) begin
               if (bad_filter) begin
                  failed_in    = 1'b1;
                  stage_vld_in = 1'b1;
               end else begin
                  kind_in = psu_pkg::filter_type'(req_if.filtered_byte[2:0]);
               end
            end
         end else begin
            // Data byte: reconstruct unless the image has failed
            stage_in.compute   = !failed_ff;
            stage_in.status    = 1'b0;
            stage_in.row_end   = row_end;
            stage_in.image_end = last;
            stage_vld_in       = !failed_ff || last;
            if (row_end) begin
               expect_in = 1'b1;
               col_in    = '0;
               for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
                  mod_in[k] = '0;
               end
               if (last) begin
                  row_in    = '0;
                  failed_in = 1'b0;
               end else begin
                  row_in = row_ff + psu_pkg::ROW_W'(1);
               end
            end else begin
               col_in = col_ff + psu_pkg::COL_W'(1);
               mod_in = mod_next;
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff    <= 1'b1;
         failed_ff    <= 1'b0;
         kind_ff      <= psu_pkg::FILT_NONE;
         col_ff       <= '0;
         row_ff       <= '0;
         stage_vld_ff <= 1'b0;
         for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
            mod_ff[k] <= '0;
         end
      end else begin
         expect_ff    <= expect_in;
         failed_ff    <= failed_in;
         kind_ff      <= kind_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         stage_vld_ff <= stage_vld_in;
         mod_ff       <= mod_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign req_if.ready = !stage_vld_ff || stage_take;
   assign stage_vld    = stage_vld_ff;
   assign stage        = stage_ff;
   assign rd_en        = accept && !expect_ff && !failed_ff;
   assign rd_addr      = idx;

endmodule

// ===== rtl/core/psu_recon.sv =====
// Reconstruction stage of png_scanline_unfilter: neighbor rings, predictor,
// line store write-back and the response register. Depends on psu_pkg and
// psu_channels.
module psu_recon (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           stage_vld,
   input  psu_pkg::stage_type             stage,
   input  logic [psu_pkg::BYTE_W-1:0]     up_byte,
   output logic                           stage_take,
   output logic                           wr_en,
   output logic [psu_pkg::LINE_AW-1:0]    wr_addr,
   output logic [psu_pkg::BYTE_W-1:0]     wr_data,
   psu_rsp_if.source                      rsp_if
);

   logic [psu_pkg::BYTE_W-1:0] left_ff [psu_pkg::MAX_PIXEL_BYTES];
   logic [psu_pkg::BYTE_W-1:0] ul_ff   [psu_pkg::MAX_PIXEL_BYTES];

   logic                       rsp_vld_ff, rsp_vld_in;
   logic [psu_pkg::BYTE_W-1:0] pixel_ff;
   logic                       status_ff;
   logic                       row_end_ff;
   logic                       image_end_ff;

   logic [psu_pkg::BYTE_W-1:0] a, b, c;
   logic [psu_pkg::BYTE_W:0]   sum_ab;
   logic [psu_pkg::BYTE_W-1:0] pred;
   logic [psu_pkg::BYTE_W-1:0] recon;

   // Neighbors, zero off the left edge and on the first row
   assign a      = stage.has_left ? left_ff[stage.slot] : '0;
   assign b      = stage.has_up ? up_byte : '0;
   assign c      = (stage.has_left && stage.has_up) ? ul_ff[stage.slot] : '0;
   assign sum_ab = {1'b0, a} + {1'b0, b};

   // Predictor select
   always_comb begin
      case (stage.kind)
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = sum_ab[psu_pkg::BYTE_W:1];
         psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
         default:             pred = '0;
      endcase
   end

   assign recon      = stage.data + pred;
   assign stage_take = stage_vld && (!rsp_vld_ff || rsp_if.ready);

   // Write back the reconstructed byte
   assign wr_en   = stage_take && stage.compute;
   assign wr_addr = stage.idx;
   assign wr_data = recon;

   // Update the rings of left and upper-left bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
            left_ff[k] <= '0;
            ul_ff[k]   <= '0;
         end
      end else if (wr_en) begin
         left_ff[stage.slot] <= recon;
         ul_ff[stage.slot]   <= b;
      end
   end

   // Response valid: load on take, drop when the sink takes it
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (stage_take) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Response payload, held while stalled
   always_ff @(posedge clock) begin
      if (stage_take) begin
         pixel_ff     <= stage.compute ? recon : '0;
         status_ff    <= stage.status;
         row_end_ff   <= stage.row_end;
         image_end_ff <= stage.image_end;
      end
   end

   assign rsp_if.valid      = rsp_vld_ff;
   assign rsp_if.pixel_byte = pixel_ff;
   assign rsp_if.status     = status_ff;
   assign rsp_if.row_end    = row_end_ff;
   assign rsp_if.image_end  = image_end_ff;

endmodule

// ===== rtl/core/png_scanline_unfilter.sv =====
// png_scanline_unfilter: PNG filter reconstruction over an inflated byte stream.
// Requests on req_if carry one stream byte each: the filter type at the start
// of a row, then line_bytes filtered data bytes. Each data byte gives one
// response on rsp_if with the reconstructed byte and row and image end marks.
// A filter type above Paeth gives one response with status set; the rest of
// that image is then dropped, except the last byte, which still reports the
// image end with a zero byte. The block re-arms at the image end.
// Configuration (bytes_per_pixel, line_bytes, row_total) is written through
// csr_we / csr_index / csr_wdata between images; values out of range clamp.
// One request per cycle is taken while rsp_if does not stall. A request is
// registered in the control stage together with the registered line store
// read, then goes through the predictor into the response register.
// When rsp_if stalls, the response register and the stage register fill and
// req_if.ready drops; nothing is lost. Synchronous reset returns the block to
// waiting for a filter byte on the first row; the line store is not cleared,
// and its read data is ignored on the first row, which writes it.
// Depends on psu_pkg, psu_channels, psu_line_ram, psu_ctrl and psu_recon.
module png_scanline_unfilter (
   input  logic                           clock,
   input  logic                           reset,
   psu_req_if.sink                        req_if,
   psu_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [psu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                        stage_vld;
   psu_pkg::stage_type          stage;
   logic                        stage_take;
   logic                        rd_en;
   logic [psu_pkg::LINE_AW-1:0] rd_addr;
   logic [psu_pkg::BYTE_W-1:0]  rd_data;
   logic                        wr_en;
   logic [psu_pkg::LINE_AW-1:0] wr_addr;
   logic [psu_pkg::BYTE_W-1:0]  wr_data;

   psu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stage_take (stage_take),
      .stage_vld  (stage_vld),
      .stage      (stage),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   psu_line_ram #(
      .DEPTH (psu_pkg::MAX_LINE_BYTES),
      .WIDTH (psu_pkg::BYTE_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psu_recon u_recon (
      .clock      (clock),
      .reset      (reset),
      .stage_vld  (stage_vld),
      .stage      (stage),
      .up_byte    (rd_data),
      .stage_take (stage_take),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== rtl/core/psu_checker.sv =====
// Port-level checks for png_scanline_unfilter, bound to the top level.
// Depends on png_scanline_unfilter_macros.svh and psu_pkg.
`include "png_scanline_unfilter_macros.svh"

module psu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [psu_pkg::BYTE_W-1:0]    rsp_pixel_byte,
   input logic                          rsp_status,
   input logic                          rsp_row_end,
   input logic                          rsp_image_end
);

   // A stalled response holds its valid, byte, status and row end
   `PSU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_byte) && $stable(rsp_status) && $stable(rsp_row_end), "stalled response changed")

   // An error response carries no byte and no end marks
   `PSU_ASSERT(a_err_clean, clock, reset, rsp_valid && rsp_status |-> rsp_pixel_byte == '0 && !rsp_row_end && !rsp_image_end, "error response carries data")

   // The image end is always a row end
   `PSU_ASSERT(a_img_row, clock, reset, rsp_valid && rsp_image_end |-> rsp_row_end, "image end without row end")

   // Reset empties the response register
   `PSU_ASSERT_NORST(a_rst_empty, clock, $past(reset) |-> !rsp_valid, "response valid after reset")

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_pixel_byte (rsp_if.pixel_byte),
   .rsp_status     (rsp_if.status),
   .rsp_row_end    (rsp_if.row_end),
   .rsp_image_end  (rsp_if.image_end)
);
